>>> design/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants and types of the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int DEPTH = 16;
    localparam int VAL_W = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_BLOCK = 3'd3,
        ST_FOUND = 3'd4,
        ST_MISS  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic shift_dn;
        logic shift_up;
        logic capture;
    } t_cell_ctrl;

endpackage

>>> design/lss_cell.sv
// ----------------------------------------------------------------------------
// lss_cell
// One stack slot: holds an entry and its search hit flag, shifts toward the
// bottom on push and toward the top (as a ring) on pop and scan rotation.
// ----------------------------------------------------------------------------
module lss_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lss_pkg::t_cell_ctrl       i_ctrl,
    input  logic [lss_pkg::VAL_W-1:0] i_key,
    input  logic                      i_valid,
    input  logic [lss_pkg::VAL_W-1:0] i_above_data,
    input  logic [lss_pkg::VAL_W-1:0] i_below_data,
    input  logic                      i_below_hit,
    output logic [lss_pkg::VAL_W-1:0] o_data,
    output logic                      o_hit
);

    logic [lss_pkg::VAL_W-1:0] r_data;
    logic [lss_pkg::VAL_W-1:0] n_data;
    logic                      r_hit;
    logic                      n_hit;

    always_comb begin
        n_data = r_data;
        n_hit  = r_hit;
        priority if (i_ctrl.shift_dn) begin
            n_data = i_above_data;
            n_hit  = 1'b0;
        end else if (i_ctrl.shift_up) begin
            n_data = i_below_data;
            n_hit  = i_below_hit;
        end else if (i_ctrl.capture) begin
            n_hit  = i_valid && (r_data == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

>>> design/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of 16-bit values built as a chain of cells, with push,
// pop, peek and a top-down search that reports the entries above the match.
//
// Channel | Handshake               | Payload
// --------+-------------------------+---------------------------------
// in      | i_in_valid / o_in_ready | i_opcode, i_value
// out     | o_out_valid/ i_out_ready| o_entry, o_status, o_last
//
// Push, pop and peek results land in the output register when the transfer is taken.
// Search first flags hits, then emits the entries above the match and a final
// found or miss status, then rotates the ring back into place.
// Reset empties the stack; entries are not cleared.
// A stalled output holds the block; no new transfer is taken until it drains.
// ----------------------------------------------------------------------------
module lifo_stack_with_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_entry,
    output logic [2:0]  o_status,
    output logic        o_last
);

    localparam int DEPTH = lss_pkg::DEPTH;
    localparam int CNT_W = lss_pkg::CNT_W;
    localparam int IDX_W = lss_pkg::IDX_W;
    localparam int VAL_W = lss_pkg::VAL_W;

    lss_pkg::t_state     r_state;
    lss_pkg::t_state     n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [IDX_W-1:0]    r_rot;
    logic [IDX_W-1:0]    n_rot;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [VAL_W-1:0]    r_entry;
    logic [VAL_W-1:0]    n_entry;
    lss_pkg::t_status    r_status;
    lss_pkg::t_status    n_status;
    logic                r_last;
    logic                n_last;

    lss_pkg::t_cell_ctrl w_ctrl;
    logic [VAL_W-1:0]    w_data [DEPTH];
    logic [DEPTH-1:0]    w_hit;
    logic                w_slot;
    logic                w_in_ready;
    logic                w_accept;
    lss_pkg::t_op        w_op;

    assign w_slot   = !r_out_valid || i_out_ready;
    assign w_accept = i_in_valid && w_in_ready;
    assign w_op     = lss_pkg::t_op'(i_opcode);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_above;
        logic [VAL_W-1:0] w_below;
        logic             w_below_hit;

        if (g == 0) begin : g_top
            assign w_above = i_value;
        end else begin : g_mid
            assign w_above = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_bot
            assign w_below     = w_data[0];
            assign w_below_hit = w_hit[0];
        end else begin : g_up
            assign w_below     = w_data[g+1];
            assign w_below_hit = w_hit[g+1];
        end

        lss_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_key        (i_value),
            .i_valid      (CNT_W'(g) < r_count),
            .i_above_data (w_above),
            .i_below_data (w_below),
            .i_below_hit  (w_below_hit),
            .o_data       (w_data[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rot       = r_rot;
        n_out_valid = r_out_valid && !i_out_ready;
        n_entry     = r_entry;
        n_status    = r_status;
        n_last      = r_last;
        w_ctrl      = '0;
        w_in_ready  = 1'b0;

        unique case (r_state)
            lss_pkg::S_IDLE: begin
                w_in_ready = w_slot;
                if (w_accept) begin
                    unique case (w_op)
                        lss_pkg::OP_PUSH: begin
                            n_out_valid = 1'b1;
                            n_entry     = '0;
                            n_last      = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = lss_pkg::ST_FULL;
                            end else begin
                                n_status        = lss_pkg::ST_OK;
                                w_ctrl.shift_dn = 1'b1;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        lss_pkg::OP_POP, lss_pkg::OP_PEEK: begin
                            n_out_valid = 1'b1;
                            n_last      = 1'b1;
                            if (r_count == '0) begin
                                n_entry  = '0;
                                n_status = lss_pkg::ST_EMPTY;
                            end else begin
                                n_entry  = w_data[0];
                                n_status = lss_pkg::ST_OK;
                                if (w_op == lss_pkg::OP_POP) begin
                                    w_ctrl.shift_up = 1'b1;
                                    n_count         = r_count - 1'b1;
                                end
                            end
                        end
                        lss_pkg::OP_SEARCH: begin
                            w_ctrl.capture = 1'b1;
                            n_rot          = '0;
                            n_state        = lss_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = lss_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            lss_pkg::S_SCAN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    priority if (!(|w_hit)) begin
                        n_entry  = '0;
                        n_status = lss_pkg::ST_MISS;
                        n_last   = 1'b1;
                        n_state  = lss_pkg::S_IDLE;
                    end else if (w_hit[0]) begin
                        n_entry  = '0;
                        n_status = lss_pkg::ST_FOUND;
                        n_last   = 1'b1;
                        n_state  = (r_rot == '0) ? lss_pkg::S_IDLE : lss_pkg::S_DRAIN;
                    end else begin
                        n_entry         = w_data[0];
                        n_status        = lss_pkg::ST_BLOCK;
                        n_last          = 1'b0;
                        w_ctrl.shift_up = 1'b1;
                        n_rot           = r_rot + 1'b1;
                    end
                end
            end
            lss_pkg::S_DRAIN: begin
                w_ctrl.shift_up = 1'b1;
                if (r_rot == IDX_W'(DEPTH - 1)) begin
                    n_rot   = '0;
                    n_state = lss_pkg::S_IDLE;
                end else begin
                    n_rot = r_rot + 1'b1;
                end
            end
            default: begin
                n_state = lss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lss_pkg::S_IDLE;
            r_count     <= '0;
            r_rot       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rot       <= n_rot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry  <= n_entry;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_entry     = r_entry;
    assign o_status    = r_status;
    assign o_last      = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_search_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == lss_pkg::OP_SEARCH) |=> r_state == lss_pkg::S_SCAN)
        else $error("search transfer did not start a scan");

    a_count_held_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lss_pkg::S_IDLE) |-> $stable(r_count))
        else $error("fill count changed during search");

    a_ring_restored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lss_pkg::S_IDLE) |-> (r_rot == '0))
        else $error("ring left rotated at idle");

endmodule
